// File: hdl/prvt_pkg.sv
package prvt_pkg;

	// Field and register widths
	localparam int COORD_WIDTH    = 16;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int TRIG_W         = 16;
	localparam int PIVOT_W        = 16;
	localparam int ZOOM_W         = 16;
	localparam int PIX_W          = 16;
	localparam int DEPTH_W        = 16;
	localparam int COLOUR_W       = 32;
	localparam int CFG_DATA_W     = 48;
	localparam int CFG_IDX_W      = 3;

	// Datapath widths, all exact
	localparam int F      = TRIG_FRAC_BITS;
	localparam int D_W    = ((COORD_WIDTH > PIVOT_W) ? COORD_WIDTH : PIVOT_W) + 1;
	localparam int S0_W   = D_W + F;
	localparam int R1_W   = S0_W + TRIG_W + 1 - F;
	localparam int A2_W   = (S0_W > R1_W) ? S0_W : R1_W;
	localparam int R2_W   = A2_W + TRIG_W + 1 - F;
	localparam int A3_W   = (R2_W > R1_W) ? R2_W : R1_W;
	localparam int R3_W   = A3_W + TRIG_W + 1 - F;
	localparam int K_W    = PIVOT_W + F;
	localparam int XP_W   = ((R3_W > K_W) ? R3_W : K_W) + 1;
	localparam int XO_W   = ((XP_W > K_W) ? XP_W : K_W) + 1;
	localparam int ZP_W   = ((R2_W > K_W) ? R2_W : K_W) + 1;
	localparam int ZO_W   = ((ZP_W > K_W) ? ZP_W : K_W) + 1;
	localparam int M_W    = XO_W + ZOOM_W + 1;
	localparam int HI_W   = M_W - F - 8;
	localparam int Q_W    = ZO_W - F;

	// Stream payload widths
	localparam int IN_W   = 3 * COORD_WIDTH + COLOUR_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 2 * PIX_W + DEPTH_W + COLOUR_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIVOT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCR_OFF   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFF = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd7;

	// Reset values
	localparam logic [31:0] TRIG_RST   = 32'h4000_0000;
	localparam logic [15:0] ZOOM_RST   = 16'd256;
	localparam logic [31:0] WINDOW_RST = 32'd70780800;

	typedef struct packed {
		logic [31:0] trig_x;
		logic [31:0] trig_y;
		logic [31:0] trig_z;
		logic [47:0] pivot;
		logic [31:0] scr_off;
		logic [15:0] depth_off;
		logic [15:0] zoom;
		logic [31:0] window;
	} cfg_t;

endpackage

// File: hdl/prvt_regs.sv
module prvt_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prvt_pkg::CFG_DATA_W-1:0] cfg_data,
	output prvt_pkg::cfg_t                  cfg
);
	import prvt_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_x    <= TRIG_RST;
			cfg_q.trig_y    <= TRIG_RST;
			cfg_q.trig_z    <= TRIG_RST;
			cfg_q.pivot     <= '0;
			cfg_q.scr_off   <= '0;
			cfg_q.depth_off <= '0;
			cfg_q.zoom      <= ZOOM_RST;
			cfg_q.window    <= WINDOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRIG_X:    cfg_q.trig_x    <= cfg_data[31:0];
				REG_TRIG_Y:    cfg_q.trig_y    <= cfg_data[31:0];
				REG_TRIG_Z:    cfg_q.trig_z    <= cfg_data[31:0];
				REG_PIVOT:     cfg_q.pivot     <= cfg_data[47:0];
				REG_SCR_OFF:   cfg_q.scr_off   <= cfg_data[31:0];
				REG_DEPTH_OFF: cfg_q.depth_off <= cfg_data[15:0];
				REG_ZOOM:      cfg_q.zoom      <= cfg_data[15:0];
				REG_WINDOW:    cfg_q.window    <= cfg_data[31:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

endmodule

// File: hdl/point_rotate_viewport_transform_unit.sv
// An accepted point passes stages 1 to 7 in order; its pixel sits in the stage-7 output register.
// Throughput: one point per cycle; the seven stages advance together and hold
// only while a pixel sits in the output register and is not taken.
// Points that fall outside the window leave no pixel and take no output slot.
// Reset clears all stage valid bits and loads the registers with their defaults.
module point_rotate_viewport_transform_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// point_x, point_y, point_z, colour
	input  logic [prvt_pkg::IN_TW-1:0]      s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_x, pixel_y, depth, pixel_colour
	output logic [prvt_pkg::OUT_TW-1:0]     m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prvt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prvt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import prvt_pkg::*;

	cfg_t cfg;

	prvt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// register fields
	logic signed [TRIG_W-1:0]  cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
	logic signed [PIVOT_W-1:0] piv_x, piv_y, piv_z, off_x, off_y, off_d;
	logic        [PIX_W-1:0]   win_w, win_h;

	assign cos_x = cfg.trig_x[31:16];
	assign sin_x = cfg.trig_x[15:0];
	assign cos_y = cfg.trig_y[31:16];
	assign sin_y = cfg.trig_y[15:0];
	assign cos_z = cfg.trig_z[31:16];
	assign sin_z = cfg.trig_z[15:0];
	assign piv_x = cfg.pivot[15:0];
	assign piv_y = cfg.pivot[31:16];
	assign piv_z = cfg.pivot[47:32];
	assign off_x = cfg.scr_off[15:0];
	assign off_y = cfg.scr_off[31:16];
	assign off_d = cfg.depth_off;
	assign win_w = cfg.window[15:0];
	assign win_h = cfg.window[31:16];

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input unpack
	logic signed [COORD_WIDTH-1:0] in_x, in_y, in_z;
	logic        [COLOUR_W-1:0]    in_col;
	assign in_x   = s_tdata[COORD_WIDTH-1:0];
	assign in_y   = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign in_z   = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign in_col = s_tdata[3*COORD_WIDTH+COLOUR_W-1:3*COORD_WIDTH];

	// stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [COLOUR_W-1:0] col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;

	logic signed [D_W-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [S0_W-1:0]  x_s2;
	logic signed [R1_W-1:0]  y_s2, z_s2;
	logic signed [R2_W-1:0]  x_s3, z_s3;
	logic signed [R1_W-1:0]  y_s3;
	logic signed [R3_W-1:0]  x_s4, y_s4;
	logic signed [R2_W-1:0]  z_s4;
	logic signed [XO_W-1:0]  x_s5, y_s5;
	logic signed [ZO_W-1:0]  z_s5;
	logic signed [M_W-1:0]   sx_s6, sy_s6;
	logic        [DEPTH_W-1:0] dep_s6;
	logic [PIX_W-1:0]    px_s7, py_s7;
	logic [DEPTH_W-1:0]  dep_s7;
	logic [COLOUR_W-1:0] col_s7;

	// stage 1: relative to pivot
	logic signed [D_W-1:0] dx_c, dy_c, dz_c;
	always_comb begin
		dx_c = D_W'(in_x) - D_W'(piv_x);
		dy_c = D_W'(in_y) - D_W'(piv_y);
		dz_c = D_W'(in_z) - D_W'(piv_z);
	end

	// stage 2: about X
	logic signed [S0_W-1:0]        x0, y0, z0;
	logic signed [S0_W+TRIG_W:0]   sum_y1, sum_z1;
	always_comb begin
		x0     = $signed({dx_s1, {F{1'b0}}});
		y0     = $signed({dy_s1, {F{1'b0}}});
		z0     = $signed({dz_s1, {F{1'b0}}});
		sum_y1 = y0 * cos_x - z0 * sin_x;
		sum_z1 = y0 * sin_x + z0 * cos_x;
	end

	// stage 3: about Y
	logic signed [A2_W-1:0]        xa2, za2;
	logic signed [A2_W+TRIG_W:0]   sum_x2, sum_z2;
	always_comb begin
		xa2    = x_s2;
		za2    = z_s2;
		sum_x2 = xa2 * cos_y + za2 * sin_y;
		sum_z2 = za2 * cos_y - xa2 * sin_y;
	end

	// stage 4: about Z
	logic signed [A3_W-1:0]        xa3, ya3;
	logic signed [A3_W+TRIG_W:0]   sum_x3, sum_y3;
	always_comb begin
		xa3    = x_s3;
		ya3    = y_s3;
		sum_x3 = xa3 * cos_z - ya3 * sin_z;
		sum_y3 = xa3 * sin_z + ya3 * cos_z;
	end

	// stage 5: pivot back, screen and depth offsets
	logic signed [XO_W-1:0] xo_c, yo_c;
	logic signed [ZO_W-1:0] zo_c;
	always_comb begin
		xo_c = x_s4 + $signed({piv_x, {F{1'b0}}}) + $signed({off_x, {F{1'b0}}});
		yo_c = y_s4 + $signed({piv_y, {F{1'b0}}}) + $signed({off_y, {F{1'b0}}});
		zo_c = z_s4 + $signed({piv_z, {F{1'b0}}}) + $signed({off_d, {F{1'b0}}});
	end

	// stage 6: zoom and depth truncate toward zero with saturation
	logic signed [ZOOM_W:0]  zm;
	logic signed [Q_W-1:0]   dq;
	logic        [DEPTH_W-1:0] dep_c;
	always_comb begin
		zm = $signed({1'b0, cfg.zoom});
		dq = z_s5[ZO_W-1:F];
		if (z_s5[ZO_W-1] && |z_s5[F-1:0])
			dq = dq + Q_W'(1);
		if (!dq[Q_W-1] && |dq[Q_W-2:DEPTH_W-1])
			dep_c = {1'b0, {(DEPTH_W-1){1'b1}}};
		else if (dq[Q_W-1] && !(&dq[Q_W-2:DEPTH_W-1]))
			dep_c = {1'b1, {(DEPTH_W-1){1'b0}}};
		else
			dep_c = dq[DEPTH_W-1:0];
	end

	// stage 7: window test on the integer part
	logic [HI_W-1:0] hx, hy;
	logic            in_win;
	always_comb begin
		hx     = sx_s6[M_W-1:F+8];
		hy     = sy_s6[M_W-1:F+8];
		in_win = !sx_s6[M_W-1] && !sy_s6[M_W-1]
			&& (hx < {{(HI_W-PIX_W){1'b0}}, win_w})
			&& (hy < {{(HI_W-PIX_W){1'b0}}, win_h});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6 && in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			dz_s1  <= dz_c;
			col_s1 <= in_col;

			x_s2   <= x0;
			y_s2   <= sum_y1[S0_W+TRIG_W:F];
			z_s2   <= sum_z1[S0_W+TRIG_W:F];
			col_s2 <= col_s1;

			x_s3   <= sum_x2[A2_W+TRIG_W:F];
			z_s3   <= sum_z2[A2_W+TRIG_W:F];
			y_s3   <= y_s2;
			col_s3 <= col_s2;

			x_s4   <= sum_x3[A3_W+TRIG_W:F];
			y_s4   <= sum_y3[A3_W+TRIG_W:F];
			z_s4   <= z_s3;
			col_s4 <= col_s3;

			x_s5   <= xo_c;
			y_s5   <= yo_c;
			z_s5   <= zo_c;
			col_s5 <= col_s4;

			sx_s6  <= x_s5 * zm;
			sy_s6  <= y_s5 * zm;
			dep_s6 <= dep_c;
			col_s6 <= col_s5;

			px_s7  <= hx[PIX_W-1:0];
			py_s7  <= hy[PIX_W-1:0];
			dep_s7 <= dep_s6;
			col_s7 <= col_s6;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = OUT_TW'({col_s7, dep_s7, py_s7, px_s7});

`ifndef SYNTHESIS
	// a pixel on the output always lies inside the window
	a_px_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (px_s7 < win_w) && (py_s7 < win_h))
		else $error("pixel outside window");

	// a new output pixel comes from a valid stage-6 item
	a_out_from_s6: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_s6))
		else $error("output without source item");

	// while stalled, the pipeline contents hold
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(vld_s6) && $stable(sx_s6))
		else $error("pipeline moved during stall");

	// an accepted point reaches stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted point lost");
`endif

endmodule

// File: sim/tb_point_rotate_viewport_transform_unit.sv
module tb_point_rotate_viewport_transform_unit;
	import prvt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     FRAC = TRIG_FRAC_BITS;
	localparam longint UNIT = longint'(1) << TRIG_FRAC_BITS;

	typedef struct {
		logic        [15:0] col;
		logic        [15:0] row;
		logic signed [15:0] depth;
		logic        [31:0] colour;
	} pixel_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_TW-1:0]      s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_TW-1:0]     m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TRIG_X;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register copy as the block holds it
	cfg_t                  view;

	logic [IN_TW-1:0]      point_queue[$];
	pixel_t                expected_pixels[$];

	int  points_queued   = 0;
	int  points_accepted = 0;
	int  pixels_checked  = 0;
	int  views_loaded    = 0;
	int  fail_count      = 0;
	int  src_gap         = 0;
	int  snk_gap         = 0;
	int  snk_draw;
	bit  src_busy        = 1'b1;
	bit  snk_busy        = 1'b1;

	point_rotate_viewport_transform_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint s16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic int hold_off(input bit busy);
		return busy ? $urandom_range(0, 13) : 0;
	endfunction

	task automatic note_error(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// rotate X, Y, Z about the pivot, move to the screen, zoom, clip to the window
	task automatic project_point(input logic [IN_TW-1:0] pt);
		longint px, py, pz, x, y, z, t, c, s, sx, sy, sz, zm, wid, hei;
		pixel_t want;
		px = s16(view.pivot[15:0]);
		py = s16(view.pivot[31:16]);
		pz = s16(view.pivot[47:32]);
		x = (s16(pt[15:0]) - px) * UNIT;
		y = (s16(pt[31:16]) - py) * UNIT;
		z = (s16(pt[47:32]) - pz) * UNIT;

		c = s16(view.trig_x[31:16]);
		s = s16(view.trig_x[15:0]);
		t = y;
		y = (t * c - z * s) >>> FRAC;
		z = (t * s + z * c) >>> FRAC;

		c = s16(view.trig_y[31:16]);
		s = s16(view.trig_y[15:0]);
		t = x;
		x = (t * c + z * s) >>> FRAC;
		z = (z * c - t * s) >>> FRAC;

		c = s16(view.trig_z[31:16]);
		s = s16(view.trig_z[15:0]);
		t = x;
		x = (t * c - y * s) >>> FRAC;
		y = (t * s + y * c) >>> FRAC;

		x += px * UNIT;
		y += py * UNIT;
		z += pz * UNIT;

		zm  = longint'(view.zoom);
		wid = longint'(view.window[15:0]);
		hei = longint'(view.window[31:16]);
		sx  = (x + s16(view.scr_off[15:0]) * UNIT) * zm;
		sy  = (y + s16(view.scr_off[31:16]) * UNIT) * zm;
		sz  = z + s16(view.depth_off) * UNIT;
		// depth rounds toward zero, unlike the rotation stages
		if (sz < 0)
			sz = -((-sz) >>> FRAC);
		else
			sz = sz >>> FRAC;

		if (sx < 0 || sy < 0 || sx >= (wid << (FRAC + 8)) || sy >= (hei << (FRAC + 8)))
			return;
		if (sz > 32767)
			sz = 32767;
		if (sz < -32768)
			sz = -32768;

		want.col    = 16'(sx >>> (FRAC + 8));
		want.row    = 16'(sy >>> (FRAC + 8));
		want.depth  = sz[15:0];
		want.colour = pt[79:48];
		expected_pixels.push_back(want);
	endtask

	task automatic check_pixel(input logic [OUT_TW-1:0] d);
		pixel_t got, want;
		got.col    = d[15:0];
		got.row    = d[31:16];
		got.depth  = d[47:32];
		got.colour = d[79:48];
		pixels_checked++;
		if (expected_pixels.size() == 0) begin
			note_error($sformatf("unexpected pixel col %0d row %0d depth %0d colour %h",
				got.col, got.row, got.depth, got.colour));
			return;
		end
		want = expected_pixels.pop_front();
		if (got.col !== want.col || got.row !== want.row || got.depth !== want.depth ||
				got.colour !== want.colour)
			note_error($sformatf(
				"pixel mismatch exp col %0d row %0d depth %0d colour %h, got col %0d row %0d depth %0d colour %h",
				want.col, want.row, want.depth, want.colour,
				got.col, got.row, got.depth, got.colour));
	endtask

	// point source
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				project_point(s_tdata);
				points_accepted++;
				if ($urandom_range(0, 63) == 0)
					src_busy = !src_busy;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (point_queue.size() > 0) begin
					s_tdata  <= point_queue.pop_front();
					s_tvalid <= 1'b1;
					src_gap  <= hold_off(src_busy);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// pixel sink
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  <= 0;
		end else if (m_tvalid && m_tready) begin
			check_pixel(m_tdata);
			if ($urandom_range(0, 63) == 0)
				snk_busy = !snk_busy;
			snk_draw = hold_off(snk_busy);
			if (snk_draw > 0) begin
				m_tready <= 1'b0;
				snk_gap  <= snk_draw - 1;
			end
		end else if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_TRIG_X:    view.trig_x    = val[31:0];
			REG_TRIG_Y:    view.trig_y    = val[31:0];
			REG_TRIG_Z:    view.trig_z    = val[31:0];
			REG_PIVOT:     view.pivot     = val[47:0];
			REG_SCR_OFF:   view.scr_off   = val[31:0];
			REG_DEPTH_OFF: view.depth_off = val[15:0];
			REG_ZOOM:      view.zoom      = val[15:0];
			REG_WINDOW:    view.window    = val[31:0];
			default:       ;
		endcase
	endtask

	task automatic load_view(input cfg_t v);
		cfg_write(REG_TRIG_X,    {16'd0, v.trig_x});
		cfg_write(REG_TRIG_Y,    {16'd0, v.trig_y});
		cfg_write(REG_TRIG_Z,    {16'd0, v.trig_z});
		cfg_write(REG_PIVOT,     v.pivot);
		cfg_write(REG_SCR_OFF,   {16'd0, v.scr_off});
		cfg_write(REG_DEPTH_OFF, {32'd0, v.depth_off});
		cfg_write(REG_ZOOM,      {32'd0, v.zoom});
		cfg_write(REG_WINDOW,    {16'd0, v.window});
		cfg_valid <= 1'b0;
		views_loaded++;
	endtask

	task automatic push_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z,
			input logic [31:0] colour);
		point_queue.push_back({colour, z, y, x});
		points_queued++;
	endtask

	// all requests taken, all pixels out, then room for points still in the pipe
	task automatic drain();
		int guard;
		guard = 0;
		while (points_accepted != points_queued)
			@(posedge clk);
		while (expected_pixels.size() > 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		while (expected_pixels.size() > 0) begin
			note_error("expected pixel never arrived");
			void'(expected_pixels.pop_front());
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic int spread(input int k);
		return int'($urandom_range(0, 2 * k)) - k;
	endfunction

	function automatic logic [31:0] pick_trig();
		real         a;
		logic [15:0] c, s;
		int          k;
		k = $urandom_range(0, 9);
		if (k < 2)
			return $urandom;
		if (k == 2)
			a = 1.5707963267948966 * $urandom_range(0, 3);
		else
			a = 6.283185307179586 * $urandom_range(0, 9999) / 10000.0;
		c = 16'($rtoi($cos(a) * 16384.0));
		s = 16'($rtoi($sin(a) * 16384.0));
		return {c, s};
	endfunction

	// random view, offsets chosen so the pivot lands near mid-window
	task automatic random_view(output cfg_t v, output int reach);
		int w, h, zm, px, py;
		v.trig_x = pick_trig();
		v.trig_y = pick_trig();
		v.trig_z = pick_trig();
		if ($urandom_range(0, 7) == 0) begin
			v.pivot[31:0]  = $urandom;
			v.pivot[47:32] = 16'($urandom_range(0, 65535));
		end else begin
			v.pivot = {clamp16(spread(1000)), clamp16(spread(1000)), clamp16(spread(1000))};
		end
		px = int'(s16(v.pivot[15:0]));
		py = int'(s16(v.pivot[31:16]));
		w  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 2048);
		h  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 2048);
		case ($urandom_range(0, 9))
			0:       zm = $urandom_range(0, 65535);
			1, 2, 3: zm = 256;
			default: zm = $urandom_range(32, 1024);
		endcase
		v.zoom      = 16'(zm);
		v.window    = {h[15:0], w[15:0]};
		v.depth_off = 16'($urandom_range(0, 65535));
		if (zm == 0) begin
			v.scr_off = $urandom;
			reach     = 1000;
		end else begin
			v.scr_off = {clamp16(h * 128 / zm - py), clamp16(w * 128 / zm - px)};
			reach     = ((w < h) ? w : h) * 64 / zm;
			if (reach < 1)
				reach = 1;
			if (reach > 20000)
				reach = 20000;
		end
	endtask

	initial begin
		cfg_t v;
		int   reach, cx, cy, cz, rounds;

		view.trig_x    = TRIG_RST;
		view.trig_y    = TRIG_RST;
		view.trig_z    = TRIG_RST;
		view.pivot     = '0;
		view.scr_off   = '0;
		view.depth_off = '0;
		view.zoom      = ZOOM_RST;
		view.window    = WINDOW_RST;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: identity rotation, 1920 x 1080 window
		push_point(16'd0, 16'd0, 16'd0, 32'h0000_0000);
		push_point(16'd1919, 16'd1079, 16'h7FFF, 32'hFFFF_FFFF);
		push_point(16'd1920, 16'd5, 16'd0, 32'h1234_5678);
		push_point(16'd5, 16'd1080, 16'd0, 32'h8765_4321);
		push_point(16'hFFFF, 16'd5, 16'd0, 32'h0F0F_0F0F);
		push_point(16'd5, 16'hFFFF, 16'd0, 32'hF0F0_F0F0);
		push_point(16'h8000, 16'h8000, 16'h8000, 32'hAAAA_AAAA);
		push_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h5555_5555);
		push_point(16'd100, 16'd200, 16'h8000, 32'h5555_5555);
		drain();

		// extreme trig, pivot and offsets, tiny zoom over the widest window
		v = view;
		v.trig_x    = 32'h8000_8000;
		v.trig_y    = 32'h7FFF_7FFF;
		v.trig_z    = 32'h7FFF_8000;
		v.pivot     = 48'h8000_7FFF_8000;
		v.scr_off   = 32'h7FFF_7FFF;
		v.depth_off = 16'h8000;
		v.zoom      = 16'd1;
		v.window    = 32'hFFFF_FFFF;
		load_view(v);
		push_point(16'd0, 16'd0, 16'd0, 32'hDEAD_BEEF);
		push_point(16'h7FFF, 16'h8000, 16'h7FFF, 32'h0000_FFFF);
		push_point(16'h8000, 16'h7FFF, 16'h8000, 32'hFFFF_0000);
		push_point(16'd1234, 16'hFB2E, 16'd555, 32'h0123_4567);
		drain();

		// largest zoom, depth saturating high, right edge of the window
		v.trig_x    = TRIG_RST;
		v.trig_y    = TRIG_RST;
		v.trig_z    = TRIG_RST;
		v.pivot     = '0;
		v.scr_off   = '0;
		v.depth_off = 16'h7FFF;
		v.zoom      = 16'hFFFF;
		load_view(v);
		push_point(16'd0, 16'd0, 16'h7FFF, 32'h1111_1111);
		push_point(16'd255, 16'd255, 16'd0, 32'h2222_2222);
		push_point(16'd256, 16'd0, 16'd0, 32'h3333_3333);
		push_point(16'd0, 16'd0, 16'h8000, 32'h4444_4444);
		drain();

		// zoom zero onto a one-pixel window, depth saturating low, 45 degrees about X
		v.trig_x    = {16'd11585, 16'd11585};
		v.depth_off = 16'h8000;
		v.zoom      = 16'd0;
		v.window    = 32'h0001_0001;
		load_view(v);
		push_point(16'h8000, 16'h7FFF, 16'h8000, 32'h7777_7777);
		push_point(16'd1, 16'd2, 16'hFFFD, 32'h8888_8888);
		drain();

		// zero width, then zero height: nothing may come out
		v = view;
		v.zoom   = ZOOM_RST;
		v.window = 32'h0438_0000;
		load_view(v);
		push_point(16'd0, 16'd0, 16'd0, 32'h9999_9999);
		push_point(16'd5, 16'd5, 16'd5, 32'hAAAA_5555);
		drain();
		v.window = 32'h0000_0780;
		load_view(v);
		push_point(16'd0, 16'd0, 16'd0, 32'hBBBB_BBBB);
		push_point(16'd5, 16'd5, 16'd5, 32'hCCCC_CCCC);
		drain();

		// random views: mostly points around the pivot, some anywhere
		rounds = 0;
		while (points_queued < 1200) begin
			random_view(v, reach);
			load_view(v);
			cx = int'(s16(v.pivot[15:0]));
			cy = int'(s16(v.pivot[31:16]));
			cz = int'(s16(v.pivot[47:32]));
			repeat (120) begin
				if ($urandom_range(0, 9) == 0)
					push_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), $urandom);
				else
					push_point(clamp16(cx + spread(reach)), clamp16(cy + spread(reach)),
						clamp16(cz + spread(reach)), $urandom);
			end
			drain();
			rounds++;
		end

		$display("Run covered %0d points in %0d random views, %0d register settings in all;",
			points_accepted, rounds, views_loaded + 1);
		$display("%0d pixels landed in the window and were checked, %0d failures.",
			pixels_checked, fail_count);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout: %0d of %0d points accepted, %0d pixels pending",
			points_accepted, points_queued, expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
hdl/prvt_pkg.sv
hdl/prvt_regs.sv
hdl/point_rotate_viewport_transform_unit.sv
sim/tb_point_rotate_viewport_transform_unit.sv
